FILE: sv/ccem_pkg.sv
// Package for the cluster chain extent mapper: input op codes, sequencer step
// numbers, control word layout and the control store. No dependencies.
`timescale 1ns / 1ps

package ccem_pkg;

  localparam int unsigned StepW = 4;
  localparam int unsigned ClusterW = 32;
  localparam int unsigned SpcW = 8;
  localparam int unsigned IndexW = 8;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_LINK  = 2'd1;
  localparam logic [1:0] OP_MAP   = 2'd2;

  localparam logic [1:0] CFG_SPC        = 2'd0;
  localparam logic [1:0] CFG_DATA_START = 2'd1;
  localparam logic [1:0] CFG_FAT_START  = 2'd2;
  localparam logic [1:0] CFG_FAT32      = 2'd3;

  localparam logic [ClusterW-1:0] END_MARK_32 = 32'h0FFF_FFFF;
  localparam logic [ClusterW-1:0] END_MARK_16 = 32'h0000_FFFF;
  localparam logic [ClusterW-1:0] FIRST_DATA_CLUSTER = 32'd2;

  localparam logic [StepW-1:0] STEP_FETCH    = 4'd0;
  localparam logic [StepW-1:0] STEP_BEGIN    = 4'd1;
  localparam logic [StepW-1:0] STEP_LINK     = 4'd2;
  localparam logic [StepW-1:0] STEP_SPAN     = 4'd3;
  localparam logic [StepW-1:0] STEP_TEST     = 4'd4;
  localparam logic [StepW-1:0] STEP_ADVANCE  = 4'd5;
  localparam logic [StepW-1:0] STEP_MISS     = 4'd6;
  localparam logic [StepW-1:0] STEP_BASE     = 4'd7;
  localparam logic [StepW-1:0] STEP_SUM      = 4'd8;
  localparam logic [StepW-1:0] STEP_REPORT   = 4'd9;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_FETCH,
    ACT_BEGIN,
    ACT_LINK,
    ACT_SPAN,
    ACT_ADVANCE,
    ACT_MISS,
    ACT_BASE,
    ACT_SUM,
    ACT_REPORT
  } act_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_DISPATCH,
    COND_HIT,
    COND_MORE,
    COND_OUTPUT
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t uw;
    uw = '{act: ACT_NONE, cond: COND_JUMP, target: STEP_FETCH};
    case (step)
      STEP_FETCH:   uw = '{act: ACT_FETCH,   cond: COND_DISPATCH, target: STEP_FETCH};
      STEP_BEGIN:   uw = '{act: ACT_BEGIN,   cond: COND_JUMP,     target: STEP_REPORT};
      STEP_LINK:    uw = '{act: ACT_LINK,    cond: COND_JUMP,     target: STEP_REPORT};
      STEP_SPAN:    uw = '{act: ACT_SPAN,    cond: COND_NEXT,     target: STEP_FETCH};
      STEP_TEST:    uw = '{act: ACT_NONE,    cond: COND_HIT,      target: STEP_BASE};
      STEP_ADVANCE: uw = '{act: ACT_ADVANCE, cond: COND_MORE,     target: STEP_SPAN};
      STEP_MISS:    uw = '{act: ACT_MISS,    cond: COND_JUMP,     target: STEP_REPORT};
      STEP_BASE:    uw = '{act: ACT_BASE,    cond: COND_NEXT,     target: STEP_FETCH};
      STEP_SUM:     uw = '{act: ACT_SUM,     cond: COND_NEXT,     target: STEP_FETCH};
      STEP_REPORT:  uw = '{act: ACT_REPORT,  cond: COND_OUTPUT,   target: STEP_FETCH};
      default:      uw = '{act: ACT_NONE,    cond: COND_JUMP,     target: STEP_FETCH};
    endcase
    return uw;
  endfunction

endpackage

FILE: sv/cluster_chain_extent_mapper.sv
// Cluster chain extent mapper top level: a microcoded sequencer over a small
// extent table and one 32x8 multiplier. Depends on ccem_pkg.
//
//   channel   direction  handshake               payload
//   cfg       in         cfg_we_i (no stall)     cfg_index_i, cfg_data_i
//   in        in         in_valid_i/in_ready_o   in_op_i, in_word_i
//   out       out        out_valid_o/out_ready_i six result fields
//
// A begin or link word goes through fetch, apply and report steps. A map word
// walks the extents with span, test and advance steps through the shared
// multiplier, then base and sum on a hit or the miss step on a miss, then report.
// Reset clears the extent table and leaves building stopped with no held sector.
// A result waits in the output register; the sequencer fetches the next word
// meanwhile and stalls only at its own report step until the output is free.
`timescale 1ns / 1ps

module cluster_chain_extent_mapper
  import ccem_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_op_i,
  input  logic [31:0]         in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_table_sector_o,
  output logic [IndexW-1:0]   out_entry_index_o,
  output logic                out_read_needed_o,
  output logic                out_chain_done_o,
  output logic [31:0]         out_physical_sector_o,
  output logic                out_map_ok_o
);

  localparam int unsigned PtrW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(MAX_EXTENTS - 1);

  logic [SpcW-1:0]     spc_q;
  logic [31:0]         data_start_q;
  logic [31:0]         fat_start_q;
  logic                fat32_q;

  logic [ClusterW-1:0] ext_first_q [MAX_EXTENTS];
  logic [ClusterW-1:0] ext_len_q   [MAX_EXTENTS];
  logic [ClusterW-1:0] cur_q;
  logic [PtrW-1:0]     fill_q;
  logic                stopped_q;
  logic [31:0]         last_sector_q;
  logic                held_q;

  logic [StepW-1:0]    pc_q, pc_d;
  logic [PtrW-1:0]     ptr_q;
  logic [ClusterW-1:0] word_q;
  logic [31:0]         prod_q;
  logic [31:0]         phys_q;
  logic                ok_q;

  logic                out_valid_q;
  logic [31:0]         out_sector_q;
  logic [IndexW-1:0]   out_index_q;
  logic                out_need_q;
  logic                out_done_q;
  logic [31:0]         out_phys_q;
  logic                out_ok_q;

  ucode_t              uw;
  logic                report_go;
  logic [ClusterW-1:0] entry;
  logic [ClusterW-1:0] end_mark;
  logic [31:0]         sector;
  logic [IndexW-1:0]   index;
  logic [ClusterW-1:0] mul_a;
  logic [31:0]         mul_p;

  assign uw = ucode_rom(pc_q);
  assign report_go = !out_valid_q || out_ready_i;
  assign in_ready_o = (pc_q == STEP_FETCH);

  assign entry = fat32_q ? word_q : {16'h0000, word_q[15:0]};
  assign end_mark = fat32_q ? END_MARK_32 : END_MARK_16;

  assign sector = fat32_q ? fat_start_q + {7'd0, cur_q[31:7]}
                          : fat_start_q + {8'd0, cur_q[31:8]};
  assign index = fat32_q ? {1'b0, cur_q[6:0]} : cur_q[7:0];

  assign mul_a = (uw.act == ACT_BASE) ? ext_first_q[ptr_q] - FIRST_DATA_CLUSTER
                                      : ext_len_q[ptr_q];
  assign mul_p = 32'(mul_a * {24'd0, spc_q});

  always_comb begin
    pc_d = pc_q + StepW'(1);
    case (uw.cond)
      COND_NEXT: begin
        pc_d = pc_q + StepW'(1);
      end
      COND_JUMP: begin
        pc_d = uw.target;
      end
      COND_DISPATCH: begin
        if (!in_valid_i) begin
          pc_d = pc_q;
        end else begin
          case (in_op_i)
            OP_BEGIN: pc_d = STEP_BEGIN;
            OP_LINK:  pc_d = STEP_LINK;
            OP_MAP:   pc_d = STEP_SPAN;
            default:  pc_d = STEP_MISS;
          endcase
        end
      end
      COND_HIT: begin
        pc_d = (word_q < prod_q) ? uw.target : pc_q + StepW'(1);
      end
      COND_MORE: begin
        pc_d = (ptr_q != LastPtr) ? uw.target : pc_q + StepW'(1);
      end
      COND_OUTPUT: begin
        pc_d = report_go ? uw.target : pc_q;
      end
      default: begin
        pc_d = STEP_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= STEP_FETCH;
      spc_q         <= SpcW'(1);
      data_start_q  <= '0;
      fat_start_q   <= '0;
      fat32_q       <= 1'b1;
      cur_q         <= '0;
      fill_q        <= '0;
      stopped_q     <= 1'b1;
      last_sector_q <= '0;
      held_q        <= 1'b0;
      ptr_q         <= '0;
      out_valid_q   <= 1'b0;
      for (int k = 0; k < MAX_EXTENTS; k++) begin
        ext_first_q[k] <= '0;
        ext_len_q[k]   <= '0;
      end
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SPC:        spc_q <= cfg_data_i[SpcW-1:0];
          CFG_DATA_START: data_start_q <= cfg_data_i;
          CFG_FAT_START:  fat_start_q <= cfg_data_i;
          CFG_FAT32:      fat32_q <= cfg_data_i[0];
          default:        ;
        endcase
      end
      if (uw.act == ACT_REPORT && report_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (uw.act)
        ACT_FETCH: begin
          ptr_q <= (in_op_i == OP_MAP) ? '0 : fill_q;
        end
        ACT_BEGIN: begin
          for (int k = 1; k < MAX_EXTENTS; k++) begin
            ext_first_q[k] <= '0;
            ext_len_q[k]   <= '0;
          end
          ext_first_q[0] <= word_q;
          ext_len_q[0]   <= 32'd1;
          cur_q          <= word_q;
          fill_q         <= '0;
          stopped_q      <= 1'b0;
          held_q         <= 1'b0;
        end
        ACT_LINK: begin
          if (!stopped_q) begin
            if (entry == cur_q + 32'd1) begin
              ext_len_q[ptr_q] <= ext_len_q[ptr_q] + 32'd1;
              cur_q            <= entry;
            end else if (ptr_q == LastPtr || entry == end_mark) begin
              stopped_q <= 1'b1;
            end else begin
              fill_q                       <= ptr_q + PtrW'(1);
              ext_first_q[ptr_q + PtrW'(1)] <= entry;
              ext_len_q[ptr_q + PtrW'(1)]   <= 32'd1;
              cur_q                        <= entry;
            end
          end
        end
        ACT_ADVANCE: begin
          if (ptr_q != LastPtr) begin
            ptr_q <= ptr_q + PtrW'(1);
          end
        end
        ACT_REPORT: begin
          if (report_go) begin
            if (!stopped_q) begin
              last_sector_q <= sector;
              held_q        <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (uw.act)
      ACT_FETCH: begin
        word_q <= in_word_i;
        phys_q <= '0;
        ok_q   <= 1'b0;
      end
      ACT_SPAN: begin
        prod_q <= mul_p;
      end
      ACT_ADVANCE: begin
        word_q <= word_q - prod_q;
      end
      ACT_MISS: begin
        phys_q <= '0;
        ok_q   <= 1'b0;
      end
      ACT_BASE: begin
        prod_q <= mul_p;
        word_q <= word_q + data_start_q;
      end
      ACT_SUM: begin
        phys_q <= word_q + prod_q;
        ok_q   <= 1'b1;
      end
      ACT_REPORT: begin
        if (report_go) begin
          out_sector_q <= sector;
          out_index_q  <= index;
          out_need_q   <= !stopped_q && (!held_q || sector != last_sector_q);
          out_done_q   <= stopped_q;
          out_phys_q   <= phys_q;
          out_ok_q     <= ok_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o           = out_valid_q;
  assign out_table_sector_o    = out_sector_q;
  assign out_entry_index_o     = out_index_q;
  assign out_read_needed_o     = out_need_q;
  assign out_chain_done_o      = out_done_q;
  assign out_physical_sector_o = out_phys_q;
  assign out_map_ok_o          = out_ok_q;

endmodule

FILE: tb/cluster_chain_extent_mapper_tb.sv
// Self-checking testbench for cluster_chain_extent_mapper: a directed table, then
// random chain walks and map lookups under several register settings, checked
// against an in-bench model of the extent table. Depends on ccem_pkg and the RTL.
`timescale 1ns / 1ps

module cluster_chain_extent_mapper_tb;
  import ccem_pkg::*;

  localparam int NumExtents = 3;
  localparam int NumPhases = 8;
  localparam int WordsPerPhase = 50;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 24;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [31:0]       table_sector;
    logic [IndexW-1:0] entry_index;
    logic              read_needed;
    logic              chain_done;
    logic [31:0]       physical_sector;
    logic              map_ok;
  } lookup_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] word;
    logic        typed;
    lookup_t     want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_index_i = CFG_SPC;
  logic [31:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        in_op_i = OP_BEGIN;
  logic [31:0]       in_word_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [31:0]       out_table_sector_o;
  logic [IndexW-1:0] out_entry_index_o;
  logic              out_read_needed_o;
  logic              out_chain_done_o;
  logic [31:0]       out_physical_sector_o;
  logic              out_map_ok_o;

  // Model of the block: registers and extent table.
  logic [7:0]  spc_cfg = 8'd1;
  logic [31:0] data_base = '0;
  logic [31:0] fat_base = '0;
  logic        fat32_cfg = 1'b1;
  logic [31:0] ext_start [NumExtents] = '{default: '0};
  logic [31:0] ext_count [NumExtents] = '{default: '0};
  logic [31:0] cur_cluster = '0;
  int          open_slot = 0;
  logic        chain_stopped = 1'b1;
  logic [31:0] held_sector = '0;
  logic        held_valid = 1'b0;

  lookup_t     lookup_fifo [$];
  lookup_t     oldest_lookup;
  int          mismatch_count = 0;
  int          useful_words = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [3:0]  stall_phase = '0;

  stim_row_t directed_rows [23] = '{
    '{OP_LINK,  32'h1234_5678, 1'b1, '{32'h0, 8'h00, 1'b0, 1'b1, 32'h0, 1'b0}},
    '{OP_MAP,   32'h0000_0000, 1'b1, '{32'h0, 8'h00, 1'b0, 1'b1, 32'h0, 1'b0}},
    '{OP_UNDEF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 8'h00, 1'b0, 1'b1, 32'h0, 1'b0}},
    '{OP_MAP,   32'hFFFF_FFFF, 1'b1, '{32'h0, 8'h00, 1'b0, 1'b1, 32'h0, 1'b0}},
    '{OP_BEGIN, 32'hFFFF_FFFF, 1'b1, '{32'h01FF_FFFF, 8'h7F, 1'b1, 1'b0, 32'h0, 1'b0}},
    '{OP_LINK,  32'h0000_0000, 1'b0, '0},
    '{OP_MAP,   32'h0000_0000, 1'b0, '0},
    '{OP_MAP,   32'h0000_0001, 1'b0, '0},
    '{OP_MAP,   32'h0000_0002, 1'b0, '0},
    '{OP_LINK,  32'h0FFF_FFFF, 1'b0, '0},
    '{OP_LINK,  32'h0000_0005, 1'b0, '0},
    '{OP_BEGIN, 32'h0000_0002, 1'b0, '0},
    '{OP_LINK,  32'h0000_0003, 1'b0, '0},
    '{OP_LINK,  32'h0000_0080, 1'b0, '0},
    '{OP_LINK,  32'h0000_0081, 1'b0, '0},
    '{OP_LINK,  32'h0FFF_FFFE, 1'b0, '0},
    '{OP_LINK,  32'h0FFF_FFFF, 1'b0, '0},
    '{OP_LINK,  32'h1000_0001, 1'b0, '0},
    '{OP_MAP,   32'h0000_0000, 1'b0, '0},
    '{OP_MAP,   32'h0000_0002, 1'b0, '0},
    '{OP_MAP,   32'h0000_0005, 1'b0, '0},
    '{OP_MAP,   32'h0000_0006, 1'b0, '0},
    '{OP_BEGIN, 32'h0000_0000, 1'b1, '{32'h0, 8'h00, 1'b1, 1'b0, 32'h0, 1'b0}}
  };

  cluster_chain_extent_mapper #(
    .MAX_EXTENTS(NumExtents)
  ) uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .in_op_i              (in_op_i),
    .in_word_i            (in_word_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_table_sector_o   (out_table_sector_o),
    .out_entry_index_o    (out_entry_index_o),
    .out_read_needed_o    (out_read_needed_o),
    .out_chain_done_o     (out_chain_done_o),
    .out_physical_sector_o(out_physical_sector_o),
    .out_map_ok_o         (out_map_ok_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic lookup_t follow_chain(input logic [1:0] op, input logic [31:0] word);
    lookup_t     res;
    logic [31:0] entry;
    logic [31:0] span;
    logic [31:0] rest;
    logic [31:0] spc_wide;
    int          k;
    res = '0;
    spc_wide = {24'h0, spc_cfg};
    case (op)
      OP_BEGIN: begin
        for (k = 0; k < NumExtents; k++) begin
          ext_start[k] = '0;
          ext_count[k] = '0;
        end
        ext_start[0] = word;
        ext_count[0] = 32'd1;
        cur_cluster = word;
        open_slot = 0;
        chain_stopped = 1'b0;
        held_valid = 1'b0;
      end
      OP_LINK: begin
        if (!chain_stopped) begin
          entry = fat32_cfg ? word : {16'h0, word[15:0]};
          if (entry == cur_cluster + 32'd1) begin
            ext_count[open_slot] = ext_count[open_slot] + 32'd1;
            cur_cluster = entry;
          end else if (open_slot == NumExtents - 1 ||
                       entry == (fat32_cfg ? END_MARK_32 : END_MARK_16)) begin
            chain_stopped = 1'b1;
          end else begin
            open_slot++;
            ext_start[open_slot] = entry;
            ext_count[open_slot] = 32'd1;
            cur_cluster = entry;
          end
        end
      end
      OP_MAP: begin
        rest = word;
        for (k = 0; k < NumExtents; k++) begin
          if (!res.map_ok) begin
            span = ext_count[k] * spc_wide;
            if (rest < span) begin
              res.map_ok = 1'b1;
              res.physical_sector = data_base + (ext_start[k] - FIRST_DATA_CLUSTER) * spc_wide
                                    + rest;
            end else begin
              rest = rest - span;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (fat32_cfg) begin
      res.table_sector = fat_base + (cur_cluster >> 7);
      res.entry_index = {1'b0, cur_cluster[6:0]};
    end else begin
      res.table_sector = fat_base + (cur_cluster >> 8);
      res.entry_index = cur_cluster[7:0];
    end
    if (!chain_stopped) begin
      res.read_needed = !held_valid || res.table_sector != held_sector;
      held_sector = res.table_sector;
      held_valid = 1'b1;
    end
    res.chain_done = chain_stopped;
    return res;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SPC:        spc_cfg = data[7:0];
      CFG_DATA_START: data_base = data;
      CFG_FAT_START:  fat_base = data;
      CFG_FAT32:      fat32_cfg = data[0];
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [31:0] word, input logic typed,
                           input lookup_t want);
    int      gap;
    lookup_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_op_i <= op;
    in_word_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    if (!(op == OP_UNDEF || (op == OP_LINK && chain_stopped))) useful_words++;
    predicted = follow_chain(op, word);
    lookup_fifo.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_phase == 4'd0) begin
      stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    out_ready_i <= stall_mask[stall_phase];
    stall_phase <= stall_phase + 4'd1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lookup_fifo.size() == 0) begin
        $error("result word with no expectation pending");
        mismatch_count++;
      end else begin
        oldest_lookup = lookup_fifo.pop_front();
        if (out_table_sector_o !== oldest_lookup.table_sector) begin
          $error("table_sector: expected %h, got %h", oldest_lookup.table_sector,
                 out_table_sector_o);
          mismatch_count++;
        end
        if (out_entry_index_o !== oldest_lookup.entry_index) begin
          $error("entry_index: expected %h, got %h", oldest_lookup.entry_index,
                 out_entry_index_o);
          mismatch_count++;
        end
        if (out_read_needed_o !== oldest_lookup.read_needed) begin
          $error("read_needed: expected %b, got %b", oldest_lookup.read_needed,
                 out_read_needed_o);
          mismatch_count++;
        end
        if (out_chain_done_o !== oldest_lookup.chain_done) begin
          $error("chain_done: expected %b, got %b", oldest_lookup.chain_done,
                 out_chain_done_o);
          mismatch_count++;
        end
        if (out_physical_sector_o !== oldest_lookup.physical_sector) begin
          $error("physical_sector: expected %h, got %h", oldest_lookup.physical_sector,
                 out_physical_sector_o);
          mismatch_count++;
        end
        if (out_map_ok_o !== oldest_lookup.map_ok) begin
          $error("map_ok: expected %b, got %b", oldest_lookup.map_ok, out_map_ok_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int          phase;
    int          phase_goal;
    int          links;
    int          maps;
    int          j;
    int          k;
    logic [31:0] word;
    logic [31:0] next_cluster;
    logic [31:0] span_sum;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].op, directed_rows[r].word, directed_rows[r].typed,
                directed_rows[r].want);
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      in_valid_i <= 1'b0;
      while (lookup_fifo.size() != 0) @(negedge clk_i);
      case (phase)
        0: begin
          write_reg(CFG_SPC, 32'd128);
          write_reg(CFG_DATA_START, 32'hFFFF_FFFF);
          write_reg(CFG_FAT_START, 32'hFFFF_FFFF);
          write_reg(CFG_FAT32, 32'd0);
        end
        1: begin
          write_reg(CFG_SPC, 32'd0);
          write_reg(CFG_DATA_START, 32'd0);
          write_reg(CFG_FAT_START, 32'd0);
          write_reg(CFG_FAT32, 32'd1);
        end
        default: begin
          write_reg(CFG_SPC, ($urandom_range(0, 3) == 0) ? 32'd1 : {24'h0, 8'($urandom)});
          write_reg(CFG_DATA_START, $urandom);
          write_reg(CFG_FAT_START, $urandom);
          write_reg(CFG_FAT32, {31'h0, 1'($urandom)});
        end
      endcase
      cfg_we_i <= 1'b0;

      phase_goal = useful_words + WordsPerPhase;
      while (useful_words < phase_goal) begin
        if ($urandom_range(0, 6) == 0) begin
          send_word(2'($urandom), $urandom, 1'b0, '0);
        end else begin
          case ($urandom_range(0, 4))
            0: word = $urandom;
            1: word = (fat32_cfg ? END_MARK_32 : END_MARK_16) - $urandom_range(0, 6);
            2: word = 32'hFFFF_FFFF - $urandom_range(0, 6);
            default: word = $urandom_range(0, fat32_cfg ? 100000 : 65000);
          endcase
          send_word(OP_BEGIN, word, 1'b0, '0);

          links = $urandom_range(0, 12);
          for (j = 0; j < links && !chain_stopped; j++) begin
            next_cluster = cur_cluster + 32'd1;
            k = $urandom_range(0, 19);
            if (k < 13) begin
              word = fat32_cfg ? next_cluster : {16'($urandom), next_cluster[15:0]};
            end else if (k < 16) begin
              word = $urandom_range(2, 200000);
            end else if (k < 18) begin
              word = fat32_cfg ? END_MARK_32 : {16'($urandom), END_MARK_16[15:0]};
            end else begin
              word = $urandom;
            end
            send_word(OP_LINK, word, 1'b0, '0);
          end
          if ($urandom_range(0, 3) == 0) send_word(OP_LINK, $urandom, 1'b0, '0);

          maps = $urandom_range(1, 5);
          for (j = 0; j < maps; j++) begin
            span_sum = '0;
            for (k = 0; k < NumExtents; k++) begin
              span_sum = span_sum + ext_count[k] * {24'h0, spc_cfg};
            end
            case ($urandom_range(0, 5))
              0: word = $urandom;
              1: word = span_sum;
              2: word = span_sum - 32'd1;
              default: word = $urandom_range(0, span_sum);
            endcase
            send_word(OP_MAP, word, 1'b0, '0);
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    while (lookup_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
